// File: hw/rtl/wwvc_pkg.sv
// package for the weighted window vote classifier
// holds widths, register defaults, config indexes and controller/datapath command types
// no dependencies
`timescale 1ns / 1ps

package wwvc_pkg;

    localparam int DEPTH_DEF   = 10;
    localparam int SAMPLE_W    = 16;
    localparam int FRAC_W      = 16;
    localparam int FILL_W      = 4;

    localparam int IN_TDATA_W  = 2 * SAMPLE_W;
    // in_band, above, below, in_abs_band, moving_avg, avg_valid, fill_count
    localparam int OUT_USED_W  = 4 + SAMPLE_W + 1 + FILL_W;
    localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

    localparam logic [FRAC_W-1:0] TOL_RST  = 16'd6554;
    localparam logic [FRAC_W-1:0] VOTE_RST = 16'd39322;
    localparam logic [FRAC_W:0]   ONE_Q16  = 17'h10000;
    localparam int                ABS_TOL  = 5;

    localparam int                 CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOTE = 2'd1;

    typedef struct packed {
        logic load;    // latch the incoming word
        logic thr;     // form thresholds, read oldest entry
        logic upd;     // append sample, fix sum and count
        logic start;   // launch window walk and average divide
        logic finish;  // register the result word
    } t_dp_cmd;

    typedef struct packed {
        logic walk_done;
        logic div_done;
    } t_dp_sts;

endpackage

// File: hw/rtl/wwvc_div.sv
// restoring unsigned divider, one quotient bit per cycle
// depends on nothing; used by the datapath for the moving average
`timescale 1ns / 1ps

module wwvc_div #(
    parameter int DVD_W = 21,
    parameter int DVS_W = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_busy,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CW = $clog2(DVD_W + 1);
    localparam logic [CW-1:0] CNT_INIT = CW'(DVD_W);

    logic             r_busy;
    logic [CW-1:0]    r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   w_trial;
    logic [DVS_W:0]   w_diff;
    logic             w_ge;
    logic [DVS_W:0]   w_next_rem;

    assign w_trial    = {r_rem, r_quo[DVD_W-1]};
    assign w_diff     = w_trial - {1'b0, r_dvs};
    assign w_ge       = (w_trial >= {1'b0, r_dvs});
    assign w_next_rem = w_ge ? w_diff : w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_INIT;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_next_rem[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

// File: hw/rtl/wwvc_dp.sv
// datapath: circular sample store, running sum, thresholds, vote walk, average divide
// depends on wwvc_pkg and wwvc_div
`timescale 1ns / 1ps

module wwvc_dp import wwvc_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [FRAC_W-1:0]      i_cfg_data,
    input  logic                   i_req_type,
    input  logic [SAMPLE_W-1:0]    i_sample,
    input  logic [SAMPLE_W-1:0]    i_target,
    output logic [OUT_TDATA_W-1:0] o_out_tdata
);

    localparam int AW      = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = SAMPLE_W + CNT_W;
    localparam int TOTAL_W = DEPTH * (DEPTH + 1) / 2;
    localparam int VW      = $clog2(TOTAL_W + 1);
    localparam int THR_W   = SAMPLE_W + FRAC_W + 2;
    localparam int VTH_W   = FRAC_W + VW;
    localparam int ATH_W   = FRAC_W + CNT_W;

    localparam logic [AW:0]      DEPTH_A = (AW + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [AW-1:0]    LAST_A  = AW'(DEPTH - 1);
    localparam logic [VW-1:0]    TOTAL_V = VW'(TOTAL_W);

    // item registers
    logic                       r_req;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [SAMPLE_W-1:0] r_target;

    // configuration
    logic [FRAC_W-1:0] r_tol;
    logic [FRAC_W-1:0] r_vote;

    // window state
    logic signed [SAMPLE_W-1:0] r_mem [DEPTH];
    logic signed [SAMPLE_W-1:0] r_mem_q;
    logic [CNT_W-1:0]           r_count;
    logic signed [SUM_W-1:0]    r_sum;
    logic [AW-1:0]              r_head;

    // thresholds
    logic signed [THR_W-1:0] r_upper;
    logic signed [THR_W-1:0] r_lower;
    logic [VTH_W-1:0]        r_vthr;
    logic [ATH_W-1:0]        r_athr;

    // walk
    logic             r_walk_act;
    logic [AW-1:0]    r_idx;
    logic             r_pipe_v;
    logic [CNT_W-1:0] r_pipe_w;
    logic [VW-1:0]    r_votes_in;
    logic [VW-1:0]    r_votes_hi;
    logic [VW-1:0]    r_votes_lo;
    logic [CNT_W-1:0] r_abs_cnt;

    logic                   r_neg;
    logic [OUT_TDATA_W-1:0] r_out_tdata;

    logic                    w_full;
    logic [AW:0]             w_rd_sum;
    logic [AW:0]             w_rd_wrap;
    logic [AW-1:0]           w_rd_addr;
    logic [AW-1:0]           w_wr_addr;
    logic                    w_mem_we;
    logic [FRAC_W:0]         w_tol_hi;
    logic [FRAC_W:0]         w_tol_lo;
    logic signed [THR_W-1:0] w_sx;
    logic signed [SAMPLE_W:0] w_d;
    logic                    w_le_up;
    logic                    w_ge_lo;
    logic [SUM_W-1:0]        w_sum_mag;
    logic                    w_div_busy;
    logic [SUM_W-1:0]        w_quo;
    logic signed [SUM_W-1:0] w_avg_s;
    logic [SAMPLE_W-1:0]     w_avg;
    logic                    w_avg_valid;
    logic                    w_in;
    logic                    w_hi;
    logic                    w_lo;
    logic                    w_abs;
    logic [FILL_W-1:0]       w_fill;

    assign w_full = (r_count == DEPTH_C);

    // oldest entry sits at r_head; position i lives at head+i modulo depth
    assign w_rd_sum  = {1'b0, r_head} + {1'b0, (i_cmd.thr ? '0 : r_idx)};
    assign w_rd_wrap = w_rd_sum - DEPTH_A;
    assign w_rd_addr = (w_rd_sum >= DEPTH_A) ? w_rd_wrap[AW-1:0] : w_rd_sum[AW-1:0];
    // head stays at zero until the store is full
    assign w_wr_addr = w_full ? r_head : r_count[AW-1:0];
    assign w_mem_we  = i_cmd.upd && !r_req;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_wr_addr] <= r_sample;
        end
        r_mem_q <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol  <= TOL_RST;
            r_vote <= VOTE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TOL:  r_tol  <= i_cfg_data;
                CFG_VOTE: r_vote <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req    <= i_req_type;
            r_sample <= $signed(i_sample);
            r_target <= $signed(i_target);
        end
    end

    // thresholds scaled by 2^16
    assign w_tol_hi = ONE_Q16 + {1'b0, r_tol};
    assign w_tol_lo = ONE_Q16 - {1'b0, r_tol};

    always_ff @(posedge i_clk) begin
        if (i_cmd.thr) begin
            r_upper <= THR_W'(r_target) * $signed(THR_W'(w_tol_hi));
            r_lower <= THR_W'(r_target) * $signed(THR_W'(w_tol_lo));
            r_vthr  <= VTH_W'(r_vote) * VTH_W'(TOTAL_V);
            r_athr  <= ATH_W'(r_vote) * ATH_W'(DEPTH_C);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_head  <= '0;
        end else if (w_mem_we) begin
            if (w_full) begin
                r_sum  <= r_sum - SUM_W'(r_mem_q) + SUM_W'(r_sample);
                r_head <= (r_head == LAST_A) ? '0 : r_head + AW'(1);
            end else begin
                r_sum   <= r_sum + SUM_W'(r_sample);
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    // two-stage walk: address issue, then compare on the registered read word
    assign w_sx    = THR_W'($signed({r_mem_q, {FRAC_W{1'b0}}}));
    assign w_d     = (SAMPLE_W + 1)'(r_mem_q) - (SAMPLE_W + 1)'(r_target);
    assign w_le_up = (w_sx <= r_upper);
    assign w_ge_lo = (w_sx >= r_lower);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk_act <= 1'b0;
            r_pipe_v   <= 1'b0;
        end else if (i_cmd.start) begin
            r_walk_act <= (r_count != '0);
            r_pipe_v   <= 1'b0;
        end else begin
            r_pipe_v <= r_walk_act;
            if (r_walk_act && (CNT_W'(r_idx) + CNT_W'(1) == r_count)) begin
                r_walk_act <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_idx      <= '0;
            r_votes_in <= '0;
            r_votes_hi <= '0;
            r_votes_lo <= '0;
            r_abs_cnt  <= '0;
        end else begin
            if (r_walk_act) begin
                r_idx    <= r_idx + AW'(1);
                r_pipe_w <= CNT_W'(r_idx) + CNT_W'(1);
            end
            if (r_pipe_v) begin
                if (w_le_up && w_ge_lo) begin
                    r_votes_in <= r_votes_in + VW'(r_pipe_w);
                end
                if (!w_le_up || (w_sx == r_upper)) begin
                    r_votes_hi <= r_votes_hi + VW'(r_pipe_w);
                end
                if (!w_ge_lo || (w_sx == r_lower)) begin
                    r_votes_lo <= r_votes_lo + VW'(r_pipe_w);
                end
                if ((w_d <= (SAMPLE_W + 1)'(ABS_TOL)) && (w_d >= -(SAMPLE_W + 1)'(ABS_TOL))) begin
                    r_abs_cnt <= r_abs_cnt + CNT_W'(1);
                end
            end
        end
    end

    // average on magnitudes so the quotient truncates toward zero
    assign w_sum_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_neg <= r_sum[SUM_W-1];
        end
    end

    wwvc_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start),
        .i_dividend (w_sum_mag),
        .i_divisor  (r_count),
        .o_busy     (w_div_busy),
        .o_quotient (w_quo)
    );

    assign w_avg_s     = r_neg ? -$signed(w_quo) : $signed(w_quo);
    assign w_avg_valid = (r_count != '0);
    assign w_avg       = w_avg_valid ? w_avg_s[SAMPLE_W-1:0] : '0;
    assign w_in        = ({r_votes_in, {FRAC_W{1'b0}}} > r_vthr);
    assign w_hi        = ({r_votes_hi, {FRAC_W{1'b0}}} > r_vthr);
    assign w_lo        = ({r_votes_lo, {FRAC_W{1'b0}}} > r_vthr);
    assign w_abs       = ({r_abs_cnt, {FRAC_W{1'b0}}} > r_athr);
    assign w_fill      = FILL_W'(r_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_tdata <= {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, w_fill, w_avg_valid, w_avg,
                            w_abs, w_lo, w_hi, w_in};
        end
    end

    assign o_out_tdata     = r_out_tdata;
    assign o_sts.walk_done = !r_walk_act && !r_pipe_v;
    assign o_sts.div_done  = !w_div_busy;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("fill count beyond window depth");

    a_head_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head != '0) |-> w_full)
        else $error("store rotated before it was full");

    a_pipe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pipe_v |-> $past(r_walk_act))
        else $error("compare stage valid without a read issued");

endmodule

// File: hw/rtl/wwvc_ctrl.sv
// controller: sequences one word through thresholds, append, walk/divide and result
// depends on wwvc_pkg
`timescale 1ns / 1ps

module wwvc_ctrl import wwvc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_THR,
        S_UPD,
        S_STRT,
        S_RUN,
        S_FIN
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.thr    = (r_state == S_THR);
    assign o_cmd.upd    = (r_state == S_UPD);
    assign o_cmd.start  = (r_state == S_STRT);
    assign o_cmd.finish = (r_state == S_FIN) && w_out_free;
    assign o_out_valid  = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_THR;
                    end
                end
                S_THR:  r_state <= S_UPD;
                S_UPD:  r_state <= S_STRT;
                S_STRT: r_state <= S_RUN;
                S_RUN: begin
                    if (i_sts.walk_done && i_sts.div_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: hw/rtl/weighted_window_vote_classifier.sv
// one word at a time: a new word is accepted only in idle, after the last result is registered
// the bit-serial divider for the average and the window walk (one store read per cycle) run side
// by side, and the controller waits for both before it registers the result
// a result waits in the output register while the next word is accepted
// synchronous active-low reset empties the window and loads register defaults; no clearing pass
`timescale 1ns / 1ps

module weighted_window_vote_classifier import wwvc_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [15:0] sample, [31:16] target
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] req_type
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] in_band, [1] above, [2] below, [3] in_abs_band, [19:4] moving_avg,
    // [20] avg_valid, [24:21] fill_count, rest zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [FRAC_W-1:0]      i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    assign o_cfg_ready = 1'b1;

    wwvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    wwvc_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req_type  (s_axis_tuser),
        .i_sample    (s_axis_tdata[SAMPLE_W-1:0]),
        .i_target    (s_axis_tdata[IN_TDATA_W-1:SAMPLE_W]),
        .o_out_tdata (m_axis_tdata)
    );

endmodule

// File: tb/weighted_window_vote_classifier_tb.sv
// testbench for weighted_window_vote_classifier: streams sample words, checks each verdict word
// against a window predictor kept in a small scoreboard class; random stalls on both sides
// depends on wwvc_pkg and the classifier rtl
`timescale 1ns / 1ps

module weighted_window_vote_classifier_tb;
    import wwvc_pkg::*;

    localparam int DEPTH     = DEPTH_DEF;
    localparam int LIMIT     = 2000;
    localparam int PHASES    = 8;
    localparam int PER_PHASE = 160;

    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_EVAL   = 1'b1;
    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // lowest bit last
    typedef struct packed {
        logic [FILL_W-1:0]         fill_count;
        logic                      avg_valid;
        logic signed [SAMPLE_W-1:0] moving_avg;
        logic                      in_abs_band;
        logic                      below;
        logic                      above;
        logic                      in_band;
    } t_verdict;

    class window_vote_board;
        logic signed [SAMPLE_W-1:0] win [DEPTH];
        int unsigned fill;
        longint      acc;
        logic [FRAC_W-1:0] tol_q16;
        logic [FRAC_W-1:0] vote_q16;
        t_verdict    verdicts_due[$];
        int          errors;

        function new();
            foreach (win[i]) win[i] = '0;
            fill     = 0;
            acc      = 0;
            tol_q16  = TOL_RST;
            vote_q16 = VOTE_RST;
            errors   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [FRAC_W-1:0] val);
            case (idx)
                CFG_TOL:  tol_q16 = val;
                CFG_VOTE: vote_q16 = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction

        function void note_sample_word(logic req, logic signed [SAMPLE_W-1:0] smp,
                                       logic signed [SAMPLE_W-1:0] tgt);
            longint t, v, tg, up, lo, s, sx, w, d, vin, vhi, vlo, nabs, total;
            t_verdict e;
            if (req == REQ_APPEND) begin
                if (fill >= DEPTH) begin
                    // full: drop oldest, shift toward position 0
                    acc = acc - win[0] + smp;
                    for (int i = 0; i < DEPTH - 1; i++) win[i] = win[i+1];
                    win[DEPTH-1] = smp;
                end else begin
                    win[fill] = smp;
                    acc += smp;
                    fill++;
                end
            end
            t  = longint'(tol_q16);
            v  = longint'(vote_q16);
            tg = longint'(tgt);
            up = tg * (65536 + t);
            lo = tg * (65536 - t);
            vin = 0; vhi = 0; vlo = 0; nabs = 0;
            for (int i = 0; i < fill; i++) begin
                s  = longint'(win[i]);
                sx = s * 65536;
                w  = longint'(i + 1);
                d  = s - tg;
                if (sx <= up && sx >= lo) vin += w;
                if (sx >= up) vhi += w;
                if (sx <= lo) vlo += w;
                if (d <= 5 && d >= -5) nabs++;
            end
            total         = DEPTH * (DEPTH + 1) / 2;
            e.in_band     = (vin * 65536 > v * total);
            e.above       = (vhi * 65536 > v * total);
            e.below       = (vlo * 65536 > v * total);
            e.in_abs_band = (nabs * 65536 > v * DEPTH);
            e.moving_avg  = (fill > 0) ? SAMPLE_W'(acc / longint'(fill)) : '0;
            e.avg_valid   = (fill > 0);
            e.fill_count  = fill[FILL_W-1:0];
            verdicts_due.push_back(e);
        endfunction

        function void compare(string name, longint exp_v, longint act_v);
            if (exp_v != act_v) begin
                $error("%s expected %0d actual %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_verdict(logic [OUT_TDATA_W-1:0] word);
            t_verdict e, got;
            if (verdicts_due.size() == 0) begin
                $error("result word %h with no verdict pending", word);
                errors++;
                return;
            end
            e   = verdicts_due.pop_front();
            got = t_verdict'(word[OUT_USED_W-1:0]);
            compare("in_band", longint'(e.in_band), longint'(got.in_band));
            compare("above", longint'(e.above), longint'(got.above));
            compare("below", longint'(e.below), longint'(got.below));
            compare("in_abs_band", longint'(e.in_abs_band), longint'(got.in_abs_band));
            compare("moving_avg", longint'(e.moving_avg), longint'(got.moving_avg));
            compare("avg_valid", longint'(e.avg_valid), longint'(got.avg_valid));
            compare("fill_count", longint'(e.fill_count), longint'(got.fill_count));
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b1;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [FRAC_W-1:0]      i_cfg_data = '0;

    window_vote_board board;
    logic quiet = 1'b0;
    int   stall_left = 0;
    int   idle_cycles = 0;
    int   tol_plan [PHASES];
    int   vote_plan [PHASES];

    weighted_window_vote_classifier dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // receiver: bursts of back-pressure, none in the last phase
    always @(posedge i_clk) begin
        if (quiet) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (m_axis_tready) begin
            if ($urandom_range(3) == 0) begin
                m_axis_tready <= 1'b0;
                stall_left    <= $urandom_range(17, 1) - 1;
            end else begin
                stall_left <= $urandom_range(30);
            end
        end else begin
            m_axis_tready <= 1'b1;
            stall_left    <= $urandom_range(40);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_verdict(m_axis_tdata);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == LIMIT) begin
            $display("weighted_window_vote_classifier: mismatch");
            $finish;
        end
    end

    function automatic int pick(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic int clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return int'(v);
    endfunction

    // call right after a rising edge; valid stays high for a following word
    task automatic send_word(logic req, int smp, int tgt);
        if (!quiet && $urandom_range(4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(17, 1)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {tgt[SAMPLE_W-1:0], smp[SAMPLE_W-1:0]};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_sample_word(req, smp[SAMPLE_W-1:0], tgt[SAMPLE_W-1:0]);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FRAC_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_random(int n, bit pause_mid);
        int     base, tgt, smp;
        logic   req;
        longint t, band_edge;
        base = 0;
        for (int k = 0; k < n; k++) begin
            if (pause_mid && k == n / 2) settle();
            // windows drift around a base so that votes build up
            if (k % 20 == 0) begin
                case ($urandom_range(3))
                    0: base = pick(-32768, 32767);
                    1: base = pick(-100, 100);
                    2: base = $urandom_range(1) ? pick(32717, 32767) : pick(-32768, -32718);
                    default: base = pick(-2000, 2000);
                endcase
            end
            tgt = clamp16(longint'(base) + pick(-3, 3));
            req = ($urandom_range(9) == 0) ? REQ_EVAL : REQ_APPEND;
            t   = longint'(board.tol_q16);
            case ($urandom_range(9))
                0, 1, 2, 3, 4: smp = clamp16(longint'(tgt) + pick(-7, 7));
                5, 6: begin
                    // land on or next to a band edge
                    if ($urandom_range(1))
                        band_edge = (longint'(tgt) * (65536 + t)) >>> 16;
                    else
                        band_edge = (longint'(tgt) * (65536 - t)) >>> 16;
                    smp = clamp16(band_edge + pick(-1, 1));
                end
                7: smp = pick(-32768, 32767);
                8: smp = $urandom_range(1) ? 32767 : -32768;
                default: smp = clamp16(longint'(base) + pick(-100, 100));
            endcase
            send_word(req, smp, tgt);
        end
    endtask

    initial begin
        board = new();
        tol_plan  = '{0, 65535, 32768, 6554, 0, 65535, 0, 0};
        vote_plan = '{0, 65535, 32768, 39322, 65535, 0, 0, 0};
        tol_plan[6]  = $urandom_range(65535);
        vote_plan[6] = $urandom_range(65535);
        tol_plan[7]  = $urandom_range(65535);
        vote_plan[7] = $urandom_range(65535);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words at reset settings
        send_word(REQ_EVAL, 0, 0);
        send_word(REQ_EVAL, 0, -32768);
        send_word(REQ_APPEND, 32767, 32767);
        send_word(REQ_APPEND, -32768, -32768);
        send_word(REQ_APPEND, 0, 0);
        send_word(REQ_APPEND, -1, 0);
        send_word(REQ_APPEND, 5, 0);
        send_word(REQ_APPEND, -5, 0);
        send_word(REQ_APPEND, 6, 0);
        send_word(REQ_APPEND, -6, 0);
        send_word(REQ_APPEND, 100, 100);
        send_word(REQ_APPEND, 110, 100);
        send_word(REQ_APPEND, 111, 100);
        send_word(REQ_APPEND, 90, 100);
        send_word(REQ_APPEND, 89, 100);
        send_word(REQ_APPEND, -110, -100);
        send_word(REQ_APPEND, -90, -100);
        send_word(REQ_EVAL, 0, 32767);
        send_word(REQ_EVAL, 0, -32768);
        send_word(REQ_APPEND, 32767, -32768);
        send_word(REQ_APPEND, 16'h5555, 16'haaaa);
        send_word(REQ_APPEND, 16'haaaa, 16'h5555);
        send_word(REQ_APPEND, -32768, 32767);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            quiet = (p == PHASES - 1);
            write_reg(CFG_TOL, tol_plan[p][FRAC_W-1:0]);
            write_reg(CFG_VOTE, vote_plan[p][FRAC_W-1:0]);
            if (p == 3) begin
                write_reg(CFG_SPARE_A, FRAC_W'($urandom));
                write_reg(CFG_SPARE_B, FRAC_W'($urandom));
            end
            run_random(PER_PHASE, p == 2);
        end

        settle();
        repeat (40) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("weighted_window_vote_classifier: match");
        else
            $display("weighted_window_vote_classifier: mismatch");
        $finish;
    end

endmodule
